// File: src/dcm_pkg.sv
// Shared constants, types and register codes for the drive command mixer.
package dcm_pkg;

   localparam int BUTTON_COUNT   = 16;
   localparam int AXIS_FRAC_BITS = 14;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Widths of the arithmetic path.
   localparam int W_W        = 25;
   localparam int TERM_W     = 34;
   localparam int LIN_MAG_W  = 18;
   localparam int ACC_W      = (AXIS_FRAC_BITS + 20 > 34) ? AXIS_FRAC_BITS + 20 : 34;
   localparam int Y_W        = ACC_W - AXIS_FRAC_BITS;
   localparam int REM_W      = 18;
   localparam int QUO_W      = 8;

   // Division by 1000 is a multiply by ceil(2^28 / 1000) and a shift, exact for
   // every dividend below 2^18.
   localparam int RECIP_W     = 19;
   localparam int RECIP_SHIFT = 28;
   localparam int PROD_W      = REM_W + RECIP_W;

   localparam logic [31:0]              AXIS_ONE        = 32'(1) << AXIS_FRAC_BITS;
   localparam logic [31:0]              DEAD_ZONE_SCALE = 32'd10;
   localparam logic signed [TERM_W-1:0] ANGLE_GAIN      = TERM_W'(179);
   localparam logic [LIN_MAG_W-1:0]     WHEEL_SCALE     = LIN_MAG_W'(1000);
   localparam logic [RECIP_W-1:0]       RECIP_MULT      = RECIP_W'(268436);
   localparam logic [Y_W-1:0]           ROUND_OFFSET    = Y_W'(500);
   localparam logic [Y_W-1:0]           SAT_LIMIT       = Y_W'(256000);
   localparam logic [QUO_W-1:0]         MAG_MAX         = 8'hFF;
   localparam logic [3:0]               DIR_LEFT_REV    = 4'hC;
   localparam logic [3:0]               DIR_RIGHT_REV   = 4'h3;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_BRAKE    = 3'd0;
   localparam logic [2:0] REG_RESUME   = 3'd1;
   localparam logic [2:0] REG_REC_ON   = 3'd2;
   localparam logic [2:0] REG_REC_OFF  = 3'd3;
   localparam logic [2:0] REG_NAV_ON   = 3'd4;
   localparam logic [2:0] REG_NAV_OFF  = 3'd5;
   localparam logic [2:0] REG_MAX_LIN  = 3'd6;
   localparam logic [2:0] REG_MAX_ANG  = 3'd7;

   typedef struct packed {
      logic               cmd;
      logic [15:0]        button_mask;
      logic signed [15:0] linear_axis;
      logic signed [15:0] angular_axis;
   } req_type;

   typedef struct packed {
      logic [7:0] left_wheel_speed;
      logic [7:0] right_wheel_speed;
      logic [3:0] direction_flags;
      logic       recording_on;
   } rsp_type;

   typedef struct packed {
      logic [3:0] brake_idx;
      logic [3:0] resume_idx;
      logic [3:0] rec_on_idx;
      logic [3:0] rec_off_idx;
      logic [3:0] nav_on_idx;
      logic [3:0] nav_off_idx;
      logic [7:0] max_lin;
      logic [7:0] max_ang;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      brake_idx:   4'd7,
      resume_idx:  4'd6,
      rec_on_idx:  4'd1,
      rec_off_idx: 4'd2,
      nav_on_idx:  4'd9,
      nav_off_idx: 4'd8,
      max_lin:     8'd40,
      max_ang:     8'd100
   };

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic mult;
      logic term;
      logic sum;
      logic prep;
      logic divide;
      logic out_load;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic emit;
      logic out_busy;
   } dp_status_type;

endpackage

// File: src/dcm_csr.sv
// Configuration register file behind the APB-style port.
module dcm_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [dcm_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [dcm_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [dcm_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready,
   output dcm_pkg::cfg_type               cfg
);
   import dcm_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] reg_idx;
   logic       wr_en;

   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_BRAKE:   cfg_in.brake_idx   = pwdata[3:0];
            REG_RESUME:  cfg_in.resume_idx  = pwdata[3:0];
            REG_REC_ON:  cfg_in.rec_on_idx  = pwdata[3:0];
            REG_REC_OFF: cfg_in.rec_off_idx = pwdata[3:0];
            REG_NAV_ON:  cfg_in.nav_on_idx  = pwdata[3:0];
            REG_NAV_OFF: cfg_in.nav_off_idx = pwdata[3:0];
            REG_MAX_LIN: cfg_in.max_lin     = pwdata[7:0];
            REG_MAX_ANG: cfg_in.max_ang     = pwdata[7:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_BRAKE:   prdata = CSR_DATA_W'(cfg_ff.brake_idx);
         REG_RESUME:  prdata = CSR_DATA_W'(cfg_ff.resume_idx);
         REG_REC_ON:  prdata = CSR_DATA_W'(cfg_ff.rec_on_idx);
         REG_REC_OFF: prdata = CSR_DATA_W'(cfg_ff.rec_off_idx);
         REG_NAV_ON:  prdata = CSR_DATA_W'(cfg_ff.nav_on_idx);
         REG_NAV_OFF: prdata = CSR_DATA_W'(cfg_ff.nav_off_idx);
         REG_MAX_LIN: prdata = CSR_DATA_W'(cfg_ff.max_lin);
         REG_MAX_ANG: prdata = CSR_DATA_W'(cfg_ff.max_ang);
         default:     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: src/dcm_ctrl.sv
// Sequencing state machine for the mixer datapath.
module dcm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  dcm_pkg::dp_status_type status,
   output dcm_pkg::dp_cmd_type    cmd
);
   import dcm_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_MULT = 7'b0000010,
      S_TERM = 7'b0000100,
      S_SUM  = 7'b0001000,
      S_PREP = 7'b0010000,
      S_DIV  = 7'b0100000,
      S_DONE = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_MULT;
            end
         end
         S_MULT: begin
            // A request from the source not in control yields no response.
            if (status.emit) begin
               cmd.mult = 1'b1;
               state_in = S_TERM;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_TERM: begin
            cmd.term = 1'b1;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.sum  = 1'b1;
            state_in = S_PREP;
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.divide = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: src/dcm_datapath.sv
// Flag latches, speed arithmetic, divide-by-1000 lanes and response register.
module dcm_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  dcm_pkg::cfg_type       cfg,
   input  dcm_pkg::req_type       req_data,
   input  dcm_pkg::dp_cmd_type    cmd,
   output dcm_pkg::dp_status_type status,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output dcm_pkg::rsp_type       rsp_data
);
   import dcm_pkg::*;

   function automatic logic pressed(input logic [15:0] mask, input logic [3:0] idx);
      pressed = (int'(idx) < BUTTON_COUNT) && mask[idx];
   endfunction

   // Scale a signed sum to (|x| >> F) + D/2, the dividend of the divide by 1000.
   function automatic logic [Y_W-1:0] round_scale(input logic signed [ACC_W-1:0] x);
      logic [ACC_W-1:0] mag;
      mag = x[ACC_W-1] ? ACC_W'(-x) : ACC_W'(x);
      round_scale = Y_W'(mag >> AXIS_FRAC_BITS) + ROUND_OFFSET;
   endfunction

   // Flags.
   logic stopped_ff, stopped_in;
   logic rec_ff, rec_in;
   logic nav_ff, nav_in;
   logic emit_ff, emit_in;

   // Captured request.
   logic               nav_item_ff, nav_item_in;
   logic               lin_pos_ff, lin_pos_in;
   logic               lin_neg_ff, lin_neg_in;
   logic signed [15:0] ang_ff, ang_in;

   // Arithmetic registers.
   logic signed [W_W-1:0]   w_ff, w_in;
   logic signed [ACC_W-1:0] lin_d_ff, lin_d_in;
   logic signed [ACC_W-1:0] term_ff, term_in;
   logic signed [ACC_W-1:0] a_ff, a_in;
   logic signed [ACC_W-1:0] c_ff, c_in;
   logic [REM_W-1:0]        rem_l_ff, rem_l_in;
   logic [REM_W-1:0]        rem_r_ff, rem_r_in;
   logic [QUO_W-1:0]        q_l_ff, q_l_in;
   logic [QUO_W-1:0]        q_r_ff, q_r_in;
   logic                    sat_l_ff, sat_l_in;
   logic                    sat_r_ff, sat_r_in;
   logic [3:0]              dir_ff, dir_in;

   // Response register.
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;

   // Intermediate values.
   logic                     s_tmp, r_tmp, n_tmp;
   logic [LIN_MAG_W-1:0]     lin_mag;
   logic signed [ACC_W-1:0]  lin_scaled;
   logic [W_W-1:0]           abs_w;
   logic                     dead;
   logic signed [TERM_W-1:0] prod;
   logic [Y_W-1:0]           y_l, y_r;
   logic [PROD_W-1:0]        recip_l, recip_r;

   assign status.emit     = emit_ff;
   assign status.out_busy = rsp_valid_ff && rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

   always_comb begin
      // Each flag pair: the set button first, then the clear button.
      s_tmp = !pressed(req_data.button_mask, cfg.resume_idx)
              && (pressed(req_data.button_mask, cfg.brake_idx) || stopped_ff);
      r_tmp = !pressed(req_data.button_mask, cfg.rec_off_idx)
              && (pressed(req_data.button_mask, cfg.rec_on_idx) || rec_ff);
      n_tmp = !pressed(req_data.button_mask, cfg.nav_off_idx)
              && (pressed(req_data.button_mask, cfg.nav_on_idx) || nav_ff);

      lin_mag    = LIN_MAG_W'(cfg.max_lin) * WHEEL_SCALE;
      lin_scaled = $signed(ACC_W'(lin_mag) << AXIS_FRAC_BITS);

      abs_w = w_ff[W_W-1] ? W_W'(-w_ff) : W_W'(w_ff);
      dead  = nav_item_ff && ((32'(abs_w) * DEAD_ZONE_SCALE) < AXIS_ONE);
      prod  = TERM_W'(w_ff) * ANGLE_GAIN;

      y_l     = round_scale(a_ff);
      y_r     = round_scale(c_ff);
      recip_l = PROD_W'(rem_l_ff) * PROD_W'(RECIP_MULT);
      recip_r = PROD_W'(rem_r_ff) * PROD_W'(RECIP_MULT);
   end

   always_comb begin
      stopped_in   = stopped_ff;
      rec_in       = rec_ff;
      nav_in       = nav_ff;
      emit_in      = emit_ff;
      nav_item_in  = nav_item_ff;
      lin_pos_in   = lin_pos_ff;
      lin_neg_in   = lin_neg_ff;
      ang_in       = ang_ff;
      w_in         = w_ff;
      lin_d_in     = lin_d_ff;
      term_in      = term_ff;
      a_in         = a_ff;
      c_in         = c_ff;
      rem_l_in     = rem_l_ff;
      rem_r_in     = rem_r_ff;
      q_l_in       = q_l_ff;
      q_r_in       = q_r_ff;
      sat_l_in     = sat_l_ff;
      sat_r_in     = sat_r_ff;
      dir_in       = dir_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (cmd.load) begin
         nav_item_in = req_data.cmd;
         lin_pos_in  = req_data.linear_axis > 16'sd0;
         lin_neg_in  = req_data.linear_axis < 16'sd0;
         ang_in      = req_data.angular_axis;
         if (!req_data.cmd) begin
            stopped_in = s_tmp;
            rec_in     = r_tmp;
            nav_in     = n_tmp;
            emit_in    = !n_tmp;
         end else begin
            emit_in = nav_ff;
         end
      end

      if (cmd.mult) begin
         if (stopped_ff) begin
            w_in     = '0;
            lin_d_in = '0;
         end else begin
            w_in = W_W'(ang_ff) * W_W'($signed({1'b0, cfg.max_ang}));
            if (lin_pos_ff) begin
               lin_d_in = lin_scaled;
            end else if (lin_neg_ff) begin
               lin_d_in = -lin_scaled;
            end else begin
               lin_d_in = '0;
            end
         end
      end

      if (cmd.term) begin
         term_in = dead ? '0 : ACC_W'(prod);
      end

      if (cmd.sum) begin
         a_in = lin_d_ff - term_ff;
         c_in = lin_d_ff + term_ff;
      end

      if (cmd.prep) begin
         rem_l_in = y_l[REM_W-1:0];
         rem_r_in = y_r[REM_W-1:0];
         sat_l_in = y_l >= SAT_LIMIT;
         sat_r_in = y_r >= SAT_LIMIT;
         dir_in   = (a_ff[ACC_W-1] ? DIR_LEFT_REV : 4'h0)
                    | (c_ff[ACC_W-1] ? DIR_RIGHT_REV : 4'h0);
      end

      // The quotient only matters below the saturation limit, where it fits a byte.
      if (cmd.divide) begin
         q_l_in = QUO_W'(recip_l >> RECIP_SHIFT);
         q_r_in = QUO_W'(recip_r >> RECIP_SHIFT);
      end

      if (cmd.out_load) begin
         rsp_in.left_wheel_speed  = sat_l_ff ? MAG_MAX : q_l_ff;
         rsp_in.right_wheel_speed = sat_r_ff ? MAG_MAX : q_r_ff;
         rsp_in.direction_flags   = dir_ff;
         rsp_in.recording_on      = rec_ff;
         rsp_valid_in             = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stopped_ff   <= 1'b0;
         rec_ff       <= 1'b0;
         nav_ff       <= 1'b0;
         emit_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         stopped_ff   <= stopped_in;
         rec_ff       <= rec_in;
         nav_ff       <= nav_in;
         emit_ff      <= emit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nav_item_ff <= nav_item_in;
      lin_pos_ff  <= lin_pos_in;
      lin_neg_ff  <= lin_neg_in;
      ang_ff      <= ang_in;
      w_ff        <= w_in;
      lin_d_ff    <= lin_d_in;
      term_ff     <= term_in;
      a_ff        <= a_in;
      c_ff        <= c_in;
      rem_l_ff    <= rem_l_in;
      rem_r_ff    <= rem_r_in;
      q_l_ff      <= q_l_in;
      q_r_ff      <= q_r_in;
      sat_l_ff    <= sat_l_in;
      sat_r_ff    <= sat_r_in;
      dir_ff      <= dir_in;
      rsp_ff      <= rsp_in;
   end

endmodule

// File: src/drive_command_mixer_top.sv
// Top level of the drive command mixer: register file, controller and datapath.
// Each request is taken through multiply, angular term, sum, rounding prep,
// divide by 1000 through a reciprocal multiply, then the response load.
// A new request is taken only after that sequence ends, and the response load waits
// while the output stalls; a request that yields no response skips the arithmetic.
// Synchronous active-high reset loads register defaults and clears the flags and rsp_valid.
module drive_command_mixer_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  dcm_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output dcm_pkg::rsp_type               rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [dcm_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [dcm_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [dcm_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import dcm_pkg::*;

   // The register file holds the button assignments and the speed limits.
   cfg_type       cfg;
   // The controller steps the datapath through one request at a time.
   dp_cmd_type    cmd;
   dp_status_type status;

   dcm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // The input is taken only while the controller sits idle; a finished response
   // waits in its own register, so a new request can be taken while it is pending.
   dcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath updates the latched flags on a joystick request, forms the wheel
   // sums in fixed point and rounds them half away from zero to saturated magnitudes.
   dcm_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
